@@ rtl/pftbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftbp_pkg
// Shared widths and register indexes of the per-flow token bucket policer.
// ----------------------------------------------------------------------------
package pftbp_pkg;

  localparam int IDX_W      = 10;
  localparam int NOW_W      = 32;
  localparam int TOKEN_W    = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_TOKEN_MAX     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REFILL_PERIOD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LOG_PERIOD    = 2'd2;

endpackage

@@ rtl/pftbp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pftbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pftbp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftbp_div
// Restoring radix-2 divider, one quotient bit per cycle, 16-bit divisor.
// ----------------------------------------------------------------------------
module pftbp_div #(
  parameter int DW = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DW-1:0]                dividend_i,
  input  logic [pftbp_pkg::CFG_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [DW-1:0]                quotient_o
);
  import pftbp_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_q, quo_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [CFG_W-1:0] dsr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic [CFG_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNT_W'(DW);
      run_d = 1'b1;
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end else begin
        rem_d = fits ? CFG_W'(trial - {1'b0, dsr_q}) : trial[CFG_W-1:0];
        quo_d = {quo_q[DW-2:0], fits};
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dsr_q <= divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  assign done_o      = run_q && (cnt_q == '0);
  assign quotient_o  = quo_q;

endmodule

@@ rtl/per_flow_token_bucket_policer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_flow_token_bucket_policer_top
// Token bucket request policer with one bucket per flow slot in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive bucket_index_i and now_seconds_i with start high;
//   the transfer happens at a clock edge where start is high and busy is low.
//   Result channel: result_valid_o is high for exactly one cycle with
//   allowed_o, log_event_o and tokens_left_o; the receiver cannot stall it.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
//   (token_max, refill_period, log_period); write only while idle.
// Timing:
//   Each request reads its bucket word from the RAM, runs a bit-serial
//   divide of the elapsed time by refill_period and writes the word
//   back. The result strobe comes in the same cycle in which busy drops.
//   With NUM_BUCKETS below 1024 the slot is first reduced modulo
//   NUM_BUCKETS by a reciprocal multiply in the extra state ST_MOD.
// Reset:
//   After reset a clearing pass writes every bucket slot and marks it
//   unused; busy stays high until it ends.
// ----------------------------------------------------------------------------
module per_flow_token_bucket_policer_top #(
  parameter int NUM_BUCKETS = 1024,
  parameter int TIME_BITS   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [pftbp_pkg::IDX_W-1:0]       bucket_index_i,
  input  logic [pftbp_pkg::NOW_W-1:0]       now_seconds_i,
  input  logic                              cfg_we_i,
  input  logic [pftbp_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [pftbp_pkg::CFG_W-1:0]       cfg_wdata_i,
  output logic                              result_valid_o,
  output logic                              allowed_o,
  output logic                              log_event_o,
  output logic [pftbp_pkg::TOKEN_W-1:0]     tokens_left_o
);
  import pftbp_pkg::*;

  localparam int  SLOT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam bit  NEED_MOD = NUM_BUCKETS < (1 << IDX_W);
  localparam int  MEM_W    = 1 + TOKEN_W + 2 * TIME_BITS;
  localparam int  USE_BIT  = MEM_W - 1;
  localparam int  TOK_LSB  = 2 * TIME_BITS;
  localparam int  REF_LSB  = TIME_BITS;
  localparam int  RCP_SH   = 2 * IDX_W;
  localparam int  RCP_W    = RCP_SH + 1;
  localparam int  PROD_W   = IDX_W + RCP_W;
  localparam logic [RCP_W-1:0]  NB_RCP = NEED_MOD ?
      RCP_W'(((1 << RCP_SH) + NUM_BUCKETS - 1) / NUM_BUCKETS) : '0;
  localparam logic [IDX_W-1:0]  NB_IDX    = NEED_MOD ? IDX_W'(NUM_BUCKETS) : '0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BUCKETS - 1);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_MOD   = 8'b0000_0100,
    ST_READ  = 8'b0000_1000,
    ST_LOAD  = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_SUM   = 8'b0100_0000,
    ST_WRITE = 8'b1000_0000
  } state_e;

  state_e                state_q, state_d;
  logic [TOKEN_W-1:0]    token_max_q;
  logic [CFG_W-1:0]      refill_period_q;
  logic [CFG_W-1:0]      log_period_q;
  logic [SLOT_W-1:0]     clr_q;
  logic [IDX_W-1:0]      idx_q;
  logic [IDX_W-1:0]      mod_quo_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [TOKEN_W-1:0]    tok_q;
  logic [TIME_BITS-1:0]  refill_q;
  logic [TIME_BITS-1:0]  logst_q;
  logic                  log_due_q;
  logic [TOKEN_W-1:0]    earned_q;
  logic                  valid_q;
  logic                  allowed_q;
  logic                  log_q;
  logic [TOKEN_W-1:0]    tokens_q;

  logic                  accept;
  logic [PROD_W-1:0]     mod_prod;
  logic [IDX_W-1:0]      mod_rem;
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [MEM_W-1:0]      mem_wdata;
  logic [MEM_W-1:0]      mem_rdata;
  logic                  in_use;
  logic [TOKEN_W-1:0]    eff_tok;
  logic [TIME_BITS-1:0]  eff_refill;
  logic [TIME_BITS-1:0]  eff_log;
  logic                  div_start;
  logic [TIME_BITS-1:0]  div_dividend;
  logic [CFG_W-1:0]      div_divisor;
  logic                  div_done;
  logic [TIME_BITS-1:0]  div_quo;
  logic [TOKEN_W:0]      fill_sum;
  logic [TOKEN_W-1:0]    filled;
  logic                  pass;
  logic [TOKEN_W-1:0]    new_tok;
  logic [TIME_BITS-1:0]  new_refill;
  logic [TIME_BITS-1:0]  new_log;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = state_q != ST_IDLE;

  assign mod_prod = PROD_W'(bucket_index_i) * PROD_W'(NB_RCP);
  assign mod_rem  = idx_q - mod_quo_q * NB_IDX;

  assign in_use     = mem_rdata[USE_BIT];
  assign eff_tok    = in_use ? mem_rdata[TOK_LSB +: TOKEN_W] : token_max_q;
  assign eff_refill = in_use ? mem_rdata[REF_LSB +: TIME_BITS] : now_q;
  assign eff_log    = in_use ? mem_rdata[0 +: TIME_BITS] : '0;

  assign div_start    = state_q == ST_LOAD;
  assign div_dividend = TIME_BITS'(now_q - eff_refill);
  assign div_divisor  = refill_period_q;

  assign fill_sum   = {1'b0, tok_q} + {1'b0, earned_q};
  assign filled     = (fill_sum > {1'b0, token_max_q}) ? token_max_q : fill_sum[TOKEN_W-1:0];
  assign pass       = filled != '0;
  assign new_tok    = pass ? filled - 1'b1 : filled;
  assign new_refill = pass ? now_q : refill_q;
  assign new_log    = (!pass && log_due_q) ? now_q : logst_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = {1'b1, new_tok, new_refill, new_log};
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else if (state_q == ST_WRITE) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == LAST_SLOT) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_d = NEED_MOD ? ST_MOD : ST_READ;
      end
      ST_MOD:   state_d = ST_READ;
      ST_READ:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_SUM;
      ST_SUM:   state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      valid_q         <= 1'b0;
      token_max_q     <= TOKEN_W'(10);
      refill_period_q <= CFG_W'(1);
      log_period_q    <= CFG_W'(60);
    end else begin
      state_q <= state_d;
      valid_q <= state_q == ST_WRITE;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TOKEN_MAX:     token_max_q     <= cfg_wdata_i;
          REG_REFILL_PERIOD: refill_period_q <= cfg_wdata_i;
          REG_LOG_PERIOD:    log_period_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q     <= bucket_index_i;
      mod_quo_q <= mod_prod[RCP_SH +: IDX_W];
      now_q     <= TIME_BITS'(now_seconds_i);
      slot_q    <= SLOT_W'(bucket_index_i);
    end
    if (state_q == ST_MOD) begin
      slot_q <= SLOT_W'(mod_rem);
    end
    if (state_q == ST_LOAD) begin
      tok_q     <= eff_tok;
      refill_q  <= eff_refill;
      logst_q   <= eff_log;
      log_due_q <= TIME_BITS'(now_q - eff_log) >= TIME_BITS'(log_period_q);
    end
    if (state_q == ST_DIV && div_done) begin
      earned_q <= (div_quo > TIME_BITS'(token_max_q)) ? token_max_q
                                                      : div_quo[TOKEN_W-1:0];
    end
    if (state_q == ST_WRITE) begin
      allowed_q <= pass;
      log_q     <= !pass && log_due_q;
      tokens_q  <= new_tok;
    end
  end

  pftbp_ram #(
    .WIDTH (MEM_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (state_q == ST_READ),
    .raddr_i (slot_q),
    .rdata_o (mem_rdata)
  );

  pftbp_div #(
    .DW (TIME_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo)
  );

  assign result_valid_o = valid_q;
  assign allowed_o      = allowed_q;
  assign log_event_o    = log_q;
  assign tokens_left_o  = tokens_q;

endmodule
